### src/edd_pkg.sv
// Shared types and constants of the error diffusion dither block.
// No dependencies; every other file of the block imports this package.
package edd_pkg;

   localparam int LINE_WORDS  = 32;
   localparam int LINE_SPAN   = LINE_WORDS * 32;

   localparam int GRAY_W      = 8;
   localparam int DOT_COL_W   = 10;
   localparam int ROW_W       = 16;
   localparam int WIDTH_REG_W = 11;
   localparam int SHIFT_W     = 12;
   localparam int ERR_W       = 12;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOT_SHIFT    = 2'd2;

   typedef logic signed [ERR_W-1:0] err_type;

   typedef struct packed {
      logic [GRAY_W-1:0] gray;
   } req_payload_type;

   typedef struct packed {
      logic                 black;
      logic [DOT_COL_W-1:0] dot_column;
      logic                 visible;
      logic [ROW_W-1:0]     row_index;
      logic                 end_of_row;
      logic                 end_of_image;
   } rsp_payload_type;

endpackage

### src/edd_if.sv
// Valid/ready channel interfaces for pixel items and dot items.
// Depends on edd_pkg for the payload types.
interface edd_req_if;
   import edd_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface edd_rsp_if;
   import edd_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### src/error_diffusion_dither.sv
// Error diffusion dither with line shift: top level, error line memory and datapath.
// Depends on edd_pkg and the channel interfaces in edd_if.sv.
//
//   channel   direction  handshake              payload
//   req_ch    in         valid/ready            gray (8 bit pixel, raster order)
//   rsp_ch    out        valid/ready            black, dot_column, visible, row_index,
//                                               end_of_row, end_of_image
//   csr_*     in         csr_we, no back-press. csr_index, csr_wdata
//
// One pixel item per cycle sustained while the output is not stalled; the memory is read at
// the accepting edge, and the error add and diffusion stage loads the output register when it fires.
// The rate is set by the right-error feedback, a loop through right_ff in the second stage.
// After reset the error line memory is swept to zero, one entry per cycle, over all
// LINE_DOTS_MAX entries (1024 by default); req_ch.ready stays low during the sweep.
// A stalled output register holds the second stage, which holds the input side.
module error_diffusion_dither #(
   parameter int LINE_DOTS_MAX = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   edd_req_if.sink                           req_ch,
   edd_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [edd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [edd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import edd_pkg::*;

   localparam int CW   = $clog2(LINE_DOTS_MAX);
   // compare width: holds the column, the width register and LINE_DOTS_MAX itself
   localparam int CMPW = ((CW > WIDTH_REG_W) ? CW : WIDTH_REG_W) + 1;
   localparam int PW   = CMPW + 1;
   localparam int XW   = 18;

   function automatic err_type sat12(input logic signed [XW-1:0] v);
      if (v > XW'(signed'(2047)))
         return err_type'(2047);
      if (v < XW'(signed'(-2048)))
         return err_type'(-2048);
      return err_type'(v[ERR_W-1:0]);
   endfunction

   // configuration registers
   logic [WIDTH_REG_W-1:0]   width_ff;
   logic [ROW_W-1:0]         height_ff;
   logic signed [SHIFT_W-1:0] shift_ff;

   // clearing sweep
   logic                     clear_busy_ff;
   logic [CW-1:0]            clear_addr_ff;

   // position counters, advanced at acceptance
   logic [CW-1:0]            col_ff, col_in;
   logic [ROW_W-1:0]         row_ff, row_in;

   // stage 1: accepted item waiting for its error add
   logic                     s1_valid_ff, s1_valid_in;
   logic [GRAY_W-1:0]        s1_gray_ff;
   logic [CW-1:0]            s1_col_ff;
   logic [ROW_W-1:0]         s1_row_ff;
   logic                     s1_last_col_ff;
   logic                     s1_last_row_ff;

   // error line memory and its forwarding
   err_type                  below_mem [LINE_DOTS_MAX];
   err_type                  rd_data_ff;
   logic                     fwd_valid_ff, fwd_valid_in;
   err_type                  fwd_data_ff, fwd_data_in;
   logic                     def_valid_ff, def_valid_in;
   logic [CW-1:0]            def_addr_ff;
   err_type                  def_data_ff;
   logic                     wr_en;
   logic [CW-1:0]            wr_addr;
   err_type                  wr_data;

   // diffusion state
   err_type                  right_ff, right_in;
   err_type                  pbl_ff, pbl_in;
   err_type                  pb_ff, pb_in;

   // output register
   logic                     out_valid_ff, out_valid_in;
   rsp_payload_type          out_data_ff, out_data_in;

   logic                     accept;
   logic                     fire;
   logic [CMPW-1:0]          width_m1;
   logic [ROW_W-1:0]         height_m1;
   logic                     last_col;
   logic                     last_row;

   err_type                  below_raw;
   err_type                  below;
   logic signed [13:0]       sum_w;
   logic signed [13:0]       err_w;
   logic                     black;
   logic signed [XW-1:0]     errx, e7, e5, e3, e1;
   err_type                  wr_left_data;
   logic signed [PW-1:0]     pos;
   logic                     visible;

   // ---------------------------------------------------------------- handshake
   assign fire          = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !clear_busy_ff && (!s1_valid_ff || fire);
   assign accept        = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.data   = out_data_ff;

   // ---------------------------------------------------------------- position
   // Clamp the width to 1 .. LINE_DOTS_MAX and the height to at least 1.
   always_comb begin
      if (width_ff == '0)
         width_m1 = '0;
      else if (CMPW'(width_ff) > CMPW'(LINE_DOTS_MAX))
         width_m1 = CMPW'(LINE_DOTS_MAX - 1);
      else
         width_m1 = CMPW'(width_ff) - CMPW'(1);
      height_m1 = (height_ff == '0) ? '0 : height_ff - ROW_W'(1);
   end

   assign last_col = CMPW'(col_ff) >= width_m1;
   assign last_row = row_ff >= height_m1;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // ---------------------------------------------------------------- error add
   // Newest write wins: a deferred write landing now, then anything caught
   // while the item waited, then the memory word read at acceptance.
   always_comb begin
      if (def_valid_ff && def_addr_ff == s1_col_ff)
         below_raw = def_data_ff;
      else if (fwd_valid_ff)
         below_raw = fwd_data_ff;
      else
         below_raw = rd_data_ff;
      // the first row gets nothing from above
      below = (s1_row_ff == '0) ? err_type'(0) : below_raw;
   end

   always_comb begin
      sum_w = $signed({6'b0, s1_gray_ff}) + 14'(below) + 14'(right_ff);
      black = sum_w < 14'sd128;
      err_w = black ? sum_w : sum_w - 14'sd255;
      errx  = XW'(err_w);
      // floor((err*k + 8) / 16) as an arithmetic shift
      e7    = ((errx <<< 3) - errx + XW'(signed'(8))) >>> 4;
      e5    = ((errx <<< 2) + errx + XW'(signed'(8))) >>> 4;
      e3    = ((errx <<< 1) + errx + XW'(signed'(8))) >>> 4;
      e1    = errx - (e7 + e5 + e3);
      wr_left_data = sat12(XW'(pbl_ff) + e3);
   end

   // Diffusion state advances only when the item moves to the output register.
   always_comb begin
      right_in     = right_ff;
      pbl_in       = pbl_ff;
      pb_in        = pb_ff;
      def_valid_in = 1'b0;
      if (fire) begin
         right_in = s1_last_col_ff ? err_type'(0) : sat12(e7);
         if (s1_last_row_ff) begin
            pbl_in = '0;
            pb_in  = '0;
         end else if (s1_last_col_ff) begin
            // the row's last below entry goes out next cycle
            def_valid_in = 1'b1;
            pbl_in       = '0;
            pb_in        = '0;
         end else begin
            pbl_in = sat12(XW'(pb_ff) + e5);
            pb_in  = sat12(e1);
         end
      end
   end

   // One write a cycle: the sweep, else a deferred end-of-row write, else the
   // below-left entry. A deferred write is always followed by a column-0 item,
   // which writes nothing, so the last two never collide.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = s1_col_ff - CW'(1);
      wr_data = wr_left_data;
      if (clear_busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr_ff;
         wr_data = '0;
      end else if (def_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = def_addr_ff;
         wr_data = def_data_ff;
      end else if (fire && !s1_last_row_ff && s1_col_ff != '0) begin
         wr_en = 1'b1;
      end
   end

   // Catch writes to the entry of the waiting item that the read could not see.
   always_comb begin
      fwd_valid_in = fwd_valid_ff;
      fwd_data_in  = fwd_data_ff;
      if (accept) begin
         fwd_valid_in = wr_en && wr_addr == col_ff;
         fwd_data_in  = wr_data;
      end else if (wr_en && wr_addr == s1_col_ff) begin
         fwd_valid_in = 1'b1;
         fwd_data_in  = wr_data;
      end
   end

   // ---------------------------------------------------------------- line shift
   always_comb begin
      pos     = $signed(PW'(s1_col_ff)) + PW'(shift_ff);
      visible = !pos[PW-1] && (pos[PW-2:0] < (PW-1)'(LINE_SPAN));
   end

   always_comb begin
      out_valid_in = fire || (out_valid_ff && !rsp_ch.ready);
      out_data_in  = out_data_ff;
      if (fire) begin
         out_data_in.black        = black;
         out_data_in.dot_column   = visible ? pos[DOT_COL_W-1:0] : '0;
         out_data_in.visible      = visible;
         out_data_in.row_index    = s1_row_ff;
         out_data_in.end_of_row   = s1_last_col_ff;
         out_data_in.end_of_image = s1_last_col_ff && s1_last_row_ff;
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !fire);

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WIDTH_REG_W'(1024);
         height_ff     <= ROW_W'(1);
         shift_ff      <= '0;
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         def_valid_ff  <= 1'b0;
         right_ff      <= '0;
         pbl_ff        <= '0;
         pb_ff         <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_REG_W-1:0];
               CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[ROW_W-1:0];
               CSR_DOT_SHIFT:    shift_ff  <= $signed(csr_wdata[SHIFT_W-1:0]);
               default: ;
            endcase
         end
         if (clear_busy_ff) begin
            clear_addr_ff <= clear_addr_ff + CW'(1);
            if (clear_addr_ff == CW'(LINE_DOTS_MAX - 1))
               clear_busy_ff <= 1'b0;
         end
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         def_valid_ff <= def_valid_in;
         right_ff     <= right_in;
         pbl_ff       <= pbl_in;
         pb_ff        <= pb_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_gray_ff     <= req_ch.data.gray;
         s1_col_ff      <= col_ff;
         s1_row_ff      <= row_ff;
         s1_last_col_ff <= last_col;
         s1_last_row_ff <= last_row;
      end
      if (fire) begin
         def_addr_ff <= s1_col_ff;
         def_data_ff <= sat12(XW'(pb_ff) + e5);
      end
      fwd_data_ff <= fwd_data_in;
      out_data_ff <= out_data_in;
   end

   // error line memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en)
         below_mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (accept)
         rd_data_ff <= below_mem[col_ff];
   end

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for error_diffusion_dither: directed and random images
// checked against an in-bench dither predictor. Depends on edd_pkg and edd_if.sv.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import edd_pkg::*;

   localparam int LINE_DOTS     = 1024;     // error line depth of the block
   localparam int SETTLE_CYCLES = 4;        // two pipeline stages plus margin
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_ITEMS  = 1150;     // includes one full-width row
   localparam int PRINT_LIMIT   = 50;

   // Pixel content styles for the random images.
   typedef enum int {
      TONE_NOISE,
      TONE_FLAT,
      TONE_THRESHOLD,
      TONE_EXTREMES,
      TONE_RAMP
   } tone_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   edd_req_if req_ch ();
   edd_rsp_if rsp_ch ();

   error_diffusion_dither dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: mirrors the block's error memory, diffusion registers,
   // raster counters and the three configuration registers.
   err_type                  error_line [LINE_DOTS];
   err_type                  carry_right    = '0;
   err_type                  below_left_acc = '0;
   err_type                  below_acc      = '0;
   logic [WIDTH_REG_W-1:0]   col_pos        = '0;
   logic [ROW_W-1:0]         row_pos        = '0;
   logic [WIDTH_REG_W-1:0]   cfg_width      = 11'd1024;
   logic [ROW_W-1:0]         cfg_height     = 16'd1;
   logic signed [SHIFT_W-1:0] cfg_shift     = '0;

   rsp_payload_type expected_dots [$];

   int  mismatch_count    = 0;
   int  dots_checked      = 0;
   int  cycle_count       = 0;
   int  hold_off_request  = 0;
   bit  tx_idling         = 1'b1;
   bit  rx_idling         = 1'b1;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a correct run ends far below this limit.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   function automatic err_type clip_err(input int v);
      if (v > 2047)
         return err_type'(2047);
      if (v < -2048)
         return err_type'(-2048);
      return err_type'(v);
   endfunction

   // Dither one pixel against the predictor state and advance it. Shares are
   // (err*k+8) floor-divided by 16; an arithmetic shift of an int does that.
   function automatic rsp_payload_type dither_pixel(input logic [GRAY_W-1:0] gray);
      int  w, h, c, below, sum, err, e7, e5, e3, e1, pos;
      bit  last_col, last_row, is_black, vis;
      rsp_payload_type dot;
      w = cfg_width;
      if (w == 0)
         w = 1;
      if (w > LINE_DOTS)
         w = LINE_DOTS;
      h = cfg_height;
      if (h == 0)
         h = 1;
      c = col_pos;
      if (c > LINE_DOTS - 1)
         c = LINE_DOTS - 1;
      // A count at or past the last index (after a shrink) ends the row or image.
      last_col = c >= w - 1;
      last_row = int'(row_pos) >= h - 1;
      // The first row never reads the error line, so stale entries are ignored.
      below    = (row_pos == 0) ? 0 : int'(error_line[c]);
      sum      = int'(gray) + below + int'(carry_right);
      is_black = sum < 128;
      err      = is_black ? sum : sum - 255;
      e7 = (err * 7 + 8) >>> 4;
      e5 = (err * 5 + 8) >>> 4;
      e3 = (err * 3 + 8) >>> 4;
      e1 = err - (e7 + e5 + e3);
      carry_right = last_col ? err_type'(0) : clip_err(e7);
      if (!last_row) begin
         if (c > 0)
            error_line[c-1] = clip_err(int'(below_left_acc) + e3);
         below_left_acc = clip_err(int'(below_acc) + e5);
         below_acc      = last_col ? err_type'(0) : clip_err(e1);
         if (last_col) begin
            error_line[c]  = below_left_acc;
            below_left_acc = '0;
            below_acc      = '0;
         end
      end else begin
         // Nothing goes below the last row.
         below_left_acc = '0;
         below_acc      = '0;
      end
      pos = c + int'(cfg_shift);
      vis = (pos >= 0) && (pos < LINE_SPAN);
      dot.black        = is_black;
      dot.dot_column   = vis ? pos[DOT_COL_W-1:0] : '0;
      dot.visible      = vis;
      dot.row_index    = row_pos;
      dot.end_of_row   = last_col;
      dot.end_of_image = last_col && last_row;
      if (last_col) begin
         col_pos = '0;
         row_pos = last_row ? '0 : row_pos + ROW_W'(1);
      end else begin
         col_pos = WIDTH_REG_W'(c + 1);
      end
      return dot;
   endfunction

   // Gap length: mostly none or short, now and then long.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_LIMIT)
         $display("[%0t] dot %0d %s: got %0d, expected %0d", $time, dots_checked, what,
                  got, want);
      mismatch_count++;
   endtask

   task automatic check_dot(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_dots.size() == 0) begin
         report_mismatch("arrived with no pixel outstanding", 1, 0);
      end else begin
         want = expected_dots.pop_front();
         if (got.black !== want.black)
            report_mismatch("black", got.black, want.black);
         if (got.dot_column !== want.dot_column)
            report_mismatch("dot_column", got.dot_column, want.dot_column);
         if (got.visible !== want.visible)
            report_mismatch("visible", got.visible, want.visible);
         if (got.row_index !== want.row_index)
            report_mismatch("row_index", got.row_index, want.row_index);
         if (got.end_of_row !== want.end_of_row)
            report_mismatch("end_of_row", got.end_of_row, want.end_of_row);
         if (got.end_of_image !== want.end_of_image)
            report_mismatch("end_of_image", got.end_of_image, want.end_of_image);
      end
      dots_checked++;
   endtask

   // Dot sink: check every accepted item, then pick ready for the next cycle.
   // A hold-off request from a test is counted down here, cycle by cycle.
   initial begin : dot_sink
      int stall_left;
      bit next_ready;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_dot(rsp_ch.data);
         if (hold_off_request > 0) begin
            stall_left       = hold_off_request;
            hold_off_request = 0;
         end
         if (stall_left > 0) begin
            next_ready = 1'b0;
            stall_left--;
         end else if (rx_idling && $urandom_range(0, 99) < 20) begin
            next_ready = 1'b0;
            stall_left = idle_gap();
         end else begin
            next_ready = 1'b1;
         end
         rsp_ch.ready <= next_ready;
      end
   end

   // Offer one pixel, hold it until accepted, then queue its predicted dot.
   // Valid stays high into the next call so back-to-back items need no toggle.
   task automatic send_pixel(input logic [GRAY_W-1:0] gray);
      int gap;
      gap = tx_idling ? idle_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data.gray <= gray;
      do
         @(posedge clock);
      while (req_ch.ready !== 1'b1);
      expected_dots.push_back(dither_pixel(gray));
   endtask

   task automatic hold_input();
      req_ch.valid <= 1'b0;
   endtask

   // Wait until every queued dot has come back, then let the pipe settle.
   task automatic wait_drained();
      do
         @(posedge clock);
      while (expected_dots.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers on an idle block; unused upper data bits get junk.
   task automatic configure(input int width, input int height, input int shift);
      logic [CSR_DATA_W-1:0] junk;
      hold_input();
      wait_drained();
      junk = CSR_DATA_W'($urandom);
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= {junk[CSR_DATA_W-1:WIDTH_REG_W], width[WIDTH_REG_W-1:0]};
      @(posedge clock);
      cfg_width = width[WIDTH_REG_W-1:0];
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= height[ROW_W-1:0];
      @(posedge clock);
      cfg_height = height[ROW_W-1:0];
      csr_index <= CSR_DOT_SHIFT;
      csr_wdata <= {junk[CSR_DATA_W-1:SHIFT_W], shift[SHIFT_W-1:0]};
      @(posedge clock);
      cfg_shift = shift[SHIFT_W-1:0];
      csr_we <= 1'b0;
   endtask

   // Reset configuration (1024 wide, one row), then shrink the width mid-row:
   // the next pixel sits past the new last column and must close the image.
   task automatic test_reset_defaults();
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd128);
      configure(2, 1, 0);
      send_pixel(8'd127);
   endtask

   // Small multi-row image: gray extremes and both sides of the threshold,
   // so error flows right, below, below-left and below-right.
   task automatic test_gray_extremes();
      logic [GRAY_W-1:0] pattern [9];
      pattern = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd255, 8'd0, 8'd1, 8'd254, 8'd128};
      configure(3, 3, 0);
      foreach (pattern[i])
         send_pixel(pattern[i]);
   endtask

   // Width zero acts as one, height zero as one, width above the line as the
   // full line; a shrink to width one then ends the wide row early.
   task automatic test_size_clamps();
      configure(0, 0, -1);
      send_pixel(8'd255);
      send_pixel(8'd0);
      configure(2047, 2, 2047);
      send_pixel(8'd200);
      send_pixel(8'd60);
      configure(1, 1, -2048);
      send_pixel(8'd90);
   endtask

   // Dots at the line edges: last visible column, one off each end, and a shift
   // of a whole line span either way.
   task automatic test_shift_edges();
      configure(2, 1, 1022);
      send_pixel(8'd10);
      send_pixel(8'd245);
      configure(2, 1, -1);
      send_pixel(8'd77);
      send_pixel(8'd178);
      configure(1, 1, 1024);
      send_pixel(8'd33);
      configure(1, 1, -1024);
      send_pixel(8'd222);
   endtask

   // Receiver holds off for a long stretch while pixels keep coming back to
   // back: the pipe fills and the block must stall its input without loss.
   task automatic test_output_stall();
      configure(8, 4, 0);
      tx_idling        = 1'b0;
      rx_idling        = 1'b0;
      hold_off_request = 300;
      repeat (32) send_pixel(GRAY_W'($urandom_range(0, 255)));
   endtask

   // Sender pauses mid-image until every dot is back, then finishes the image.
   task automatic test_drain_pause();
      configure(6, 3, 3);
      tx_idling = 1'b1;
      rx_idling = 1'b1;
      repeat (9) send_pixel(GRAY_W'($urandom_range(0, 255)));
      hold_input();
      wait_drained();
      repeat (9) send_pixel(GRAY_W'($urandom_range(0, 255)));
   endtask

   function automatic int random_shift(input int weff);
      int r;
      r = $urandom_range(0, 99);
      if (r < 35)
         return 0;
      if (r < 55)
         return int'($urandom_range(0, 16)) - 8;
      if (r < 75)
         return int'($urandom_range(0, 4095)) - 2048;
      if (r < 83)
         return LINE_SPAN - weff + int'($urandom_range(0, 4)) - 2;
      if (r < 90)
         return -weff + int'($urandom_range(0, 4)) - 2;
      case ($urandom_range(0, 3))
         0:       return -1024;
         1:       return 1024;
         2:       return -2048;
         default: return 2047;
      endcase
   endfunction

   function automatic logic [GRAY_W-1:0] pixel_value(input tone_type tone, input int level,
                                                     input int col, input int weff);
      case (tone)
         TONE_FLAT:      return GRAY_W'(level);
         TONE_THRESHOLD: return GRAY_W'($urandom_range(112, 143));
         TONE_EXTREMES:  return $urandom_range(0, 1) ? 8'd255 : 8'd0;
         TONE_RAMP:      return GRAY_W'((col * 255) / ((weff > 1) ? weff - 1 : 1));
         default:        return GRAY_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Random images: mostly complete images of small random size, content and
   // shift; some cut short or run over into the next image, some with a huge
   // height that never finishes. One full-width row reaches the last column.
   task automatic test_random_images();
      int       sent, w, h, weff, heff, n, r, level;
      bit       wide_done;
      tone_type tone;
      sent      = 0;
      wide_done = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         tx_idling = ($urandom_range(0, 3) != 0);
         rx_idling = ($urandom_range(0, 3) != 0);
         level     = $urandom_range(0, 255);
         r         = $urandom_range(0, 99);
         tone      = (r < 40) ? TONE_NOISE : tone_type'($urandom_range(1, 4));
         if (!wide_done && sent >= 400) begin
            wide_done = 1'b1;
            w    = $urandom_range(LINE_DOTS, 2047);
            h    = 1;
            weff = LINE_DOTS;
            n    = LINE_DOTS;
            tone = TONE_NOISE;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 8)
               w = 1;
            else if (r < 45)
               w = $urandom_range(2, 8);
            else if (r < 85)
               w = $urandom_range(9, 40);
            else if (r < 95)
               w = $urandom_range(41, 160);
            else
               w = 0;
            weff = (w == 0) ? 1 : w;
            r = $urandom_range(0, 99);
            if (r < 5)
               h = 0;
            else if (r < 85)
               h = $urandom_range(1, 6);
            else
               h = $urandom_range(7, 24);
            heff = (h == 0) ? 1 : h;
            while (weff * heff > 400) begin
               heff--;
               h = heff;
            end
            n = weff * heff;
            // Break a few images: stop early, overrun, or never reach the end.
            r = $urandom_range(0, 99);
            if (r < 12) begin
               n = $urandom_range(1, n);
            end else if (r < 16) begin
               h = $urandom_range(0, 65535);
               n = $urandom_range(1, (n < 120) ? n : 120);
            end else if (r < 20) begin
               n = n + $urandom_range(1, weff);
            end
         end
         configure(w, h, random_shift(weff));
         for (int i = 0; i < n; i++)
            send_pixel(pixel_value(tone, level, i % weff, weff));
         sent += n;
      end
   endtask

   initial begin : stimulus
      foreach (error_line[i])
         error_line[i] = '0;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data      <= '0;
      csr_we           <= 1'b0;
      csr_index        <= CSR_IMAGE_WIDTH;
      csr_wdata        <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Input stays blocked during the error line sweep; the handshake waits.
      test_reset_defaults();
      test_gray_extremes();
      test_size_clamps();
      test_shift_edges();
      test_output_stall();
      test_drain_pause();
      test_random_images();

      hold_input();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### sim.f
src/edd_pkg.sv
src/edd_if.sv
src/error_diffusion_dither.sv
tb/sv/testbench.sv
